// ----- sv/rgbhsv_pkg.sv -----
// Shared widths and pipeline payload type for the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int CH_W       = 8;   // channel and result byte width
  localparam int SUM_W      = 11;  // hue sector sum, below 6*255
  localparam int HNUM_W     = 19;  // 255 * sum
  localparam int HDIV_W     = 11;  // 6 * chroma
  localparam int SNUM_W     = 16;  // 255 * chroma
  localparam int DIV_STAGES = CH_W;

  typedef struct packed {
    logic              grey;
    logic [CH_W-1:0]   brightness;
    logic [HNUM_W-1:0] hue_rem;
    logic [HDIV_W-1:0] hue_div;
    logic [SNUM_W-1:0] sat_rem;
    logic [CH_W-1:0]   sat_div;
    logic [CH_W-1:0]   hue_q;
    logic [CH_W-1:0]   sat_q;
  } rgbhsv_div_t;

endpackage

// ----- sv/rgbhsv_front.sv -----
// Front stages: channel max/min, chroma, hue sector sum, then dividend and divisor setup.
module rgbhsv_front
  import rgbhsv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [CH_W-1:0]   blue,
  input  logic [CH_W-1:0]   green,
  input  logic [CH_W-1:0]   red,
  output logic              out_valid,
  output rgbhsv_div_t       out_data
);

  logic [CH_W-1:0]  mx, mn, c;
  logic [SUM_W-1:0] sum;

  logic             va_r;
  logic [CH_W-1:0]  mx_r, c_r;
  logic [SUM_W-1:0] sum_r;

  logic             vb_r;
  rgbhsv_div_t      dt_r, dt_nxt;

  always_comb begin
    logic [CH_W-1:0] t_mx, t_mn;
    t_mx = (red > green) ? red : green;
    mx   = (t_mx > blue) ? t_mx : blue;
    t_mn = (red < green) ? red : green;
    mn   = (t_mn < blue) ? t_mn : blue;
    c    = mx - mn;
    // Sector sums stay in [0, 6C); modulo arithmetic in SUM_W bits is exact.
    priority if (mx == blue) begin
      sum = (SUM_W'(c) << 2) + SUM_W'(red) - SUM_W'(green);
    end else if (mx == green) begin
      sum = (SUM_W'(c) << 1) + SUM_W'(blue) - SUM_W'(red);
    end else if (green >= blue) begin
      sum = SUM_W'(green) - SUM_W'(blue);
    end else begin
      sum = (SUM_W'(c) << 2) + (SUM_W'(c) << 1) + SUM_W'(green) - SUM_W'(blue);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mx_r  <= mx;
    c_r   <= c;
    sum_r <= sum;
  end

  // x * 255 as (x << 8) - x, 6C as 4C + 2C.
  always_comb begin
    dt_nxt            = '0;
    dt_nxt.grey       = (c_r == '0);
    dt_nxt.brightness = mx_r;
    dt_nxt.hue_rem    = (HNUM_W'(sum_r) << CH_W) - HNUM_W'(sum_r);
    dt_nxt.hue_div    = (HDIV_W'(c_r) << 2) + (HDIV_W'(c_r) << 1);
    dt_nxt.sat_rem    = (SNUM_W'(c_r) << CH_W) - SNUM_W'(c_r);
    dt_nxt.sat_div    = mx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    dt_r <= dt_nxt;
  end

  assign out_valid = vb_r;
  assign out_data  = dt_r;

endmodule

// ----- sv/rgbhsv_div_stage.sv -----
// One restoring-division step for both the hue and the saturation quotients.
module rgbhsv_div_stage
  import rgbhsv_pkg::*;
#(
  parameter int BIT_IDX = 0
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  rgbhsv_div_t in_data,
  output logic        out_valid,
  output rgbhsv_div_t out_data
);

  logic [HNUM_W-1:0] hue_sh;
  logic [SNUM_W-1:0] sat_sh;
  logic              hue_ge, sat_ge;
  logic              valid_r;
  rgbhsv_div_t       data_r, data_nxt;

  assign hue_sh = HNUM_W'(in_data.hue_div) << BIT_IDX;
  assign sat_sh = SNUM_W'(in_data.sat_div) << BIT_IDX;
  assign hue_ge = (in_data.hue_rem >= hue_sh);
  assign sat_ge = (in_data.sat_rem >= sat_sh);

  always_comb begin
    data_nxt = in_data;
    data_nxt.hue_q[BIT_IDX] = hue_ge;
    data_nxt.sat_q[BIT_IDX] = sat_ge;
    if (hue_ge) begin
      data_nxt.hue_rem = in_data.hue_rem - hue_sh;
    end
    if (sat_ge) begin
      data_nxt.sat_rem = in_data.sat_rem - sat_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- sv/rgb_to_hsv_converter.sv -----
// Top level of the pipelined 8-bit RGB to HSV converter.
//
// Usage: drive in_blue, in_green and in_red and raise start for one cycle per
// pixel. busy is always low, so a request is taken at every edge where start
// is high, one pixel per clock with no gaps needed.
// Each request gives exactly one result: out_valid is high for one cycle
// with out_hue, out_saturation and out_brightness. Results leave in request
// order, passing through two front stages (max/min and
// sector sum, then dividend setup), eight restoring-division stages that
// each settle one quotient bit of hue and of saturation, and one output
// register. Grey pixels (zero chroma) come out with hue and saturation zero.
// Throughput is one pixel per cycle; the division stages are the depth.
// A synchronous reset (rst_n low) clears all valid bits, dropping any pixel
// in flight; no result appears until new requests arrive.
// The receiver cannot stall: results must be taken in the cycle shown.
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [CH_W-1:0] in_blue,
  input  logic [CH_W-1:0] in_green,
  input  logic [CH_W-1:0] in_red,
  output logic            out_valid,
  output logic [CH_W-1:0] out_hue,
  output logic [CH_W-1:0] out_saturation,
  output logic [CH_W-1:0] out_brightness
);

  logic        pipe_v [0:DIV_STAGES];
  rgbhsv_div_t pipe_d [0:DIV_STAGES];

  logic            out_valid_r;
  logic [CH_W-1:0] hue_r, sat_r, bright_r;

  assign busy = 1'b0;

  rgbhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .blue     (in_blue),
    .green    (in_green),
    .red      (in_red),
    .out_valid(pipe_v[0]),
    .out_data (pipe_d[0])
  );

  // Quotient bits from the top down, one per stage.
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    rgbhsv_div_stage #(
      .BIT_IDX(DIV_STAGES - 1 - i)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (pipe_v[i]),
      .in_data  (pipe_d[i]),
      .out_valid(pipe_v[i+1]),
      .out_data (pipe_d[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pipe_v[DIV_STAGES];
    end
  end

  // Zero chroma divides by zero in the stages; force hue and saturation to zero.
  always_ff @(posedge clk) begin
    hue_r    <= pipe_d[DIV_STAGES].grey ? '0 : pipe_d[DIV_STAGES].hue_q;
    sat_r    <= pipe_d[DIV_STAGES].grey ? '0 : pipe_d[DIV_STAGES].sat_q;
    bright_r <= pipe_d[DIV_STAGES].brightness;
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the pipelined RGB to HSV converter.
`timescale 1ns / 100ps

module tb;
  import rgbhsv_pkg::*;

  localparam int PIPE_LATENCY = 11;
  localparam int RANDOM_PIXELS = 600;
  localparam int CYCLE_LIMIT = 60000;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] brightness;
  } hsv_t;

  typedef enum int {SEC_GREY, SEC_BLUE, SEC_GREEN, SEC_RED_UP, SEC_RED_WRAP} sector_t;

  typedef struct {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    bit              known;
    hsv_t            want;
  } pixel_row_t;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  logic [CH_W-1:0] in_blue;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_red;
  logic            out_valid;
  logic [CH_W-1:0] out_hue;
  logic [CH_W-1:0] out_saturation;
  logic [CH_W-1:0] out_brightness;

  hsv_t pending_hsv[$];
  int   err_count;
  int   checked_count;
  int   pixel_count;
  int   cycle_count;
  int   sector_hits[5];

  rgb_to_hsv_converter uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_blue       (in_blue),
    .in_green      (in_green),
    .in_red        (in_red),
    .out_valid     (out_valid),
    .out_hue       (out_hue),
    .out_saturation(out_saturation),
    .out_brightness(out_brightness)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact integer HSV: blue wins ties over green, green over red.
  function automatic void predict_hsv(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                                      input logic [CH_W-1:0] r, output hsv_t res,
                                      output sector_t sec);
    int bi;
    int gi;
    int ri;
    int mx;
    int mn;
    int chroma;
    int sum;
    bi = int'(b);
    gi = int'(g);
    ri = int'(r);
    mx = (bi > gi) ? bi : gi;
    mx = (mx > ri) ? mx : ri;
    mn = (bi < gi) ? bi : gi;
    mn = (mn < ri) ? mn : ri;
    chroma = mx - mn;
    res = '0;
    res.brightness = CH_W'(mx);
    sec = SEC_GREY;
    if (chroma != 0) begin
      res.saturation = CH_W'((255 * chroma) / mx);
      if (mx == bi) begin
        sum = 4 * chroma + ri - gi;
        sec = SEC_BLUE;
      end else if (mx == gi) begin
        sum = 2 * chroma + bi - ri;
        sec = SEC_GREEN;
      end else if (gi >= bi) begin
        sum = gi - bi;
        sec = SEC_RED_UP;
      end else begin
        sum = 6 * chroma + gi - bi;
        sec = SEC_RED_WRAP;
      end
      res.hue = CH_W'((255 * sum) / (6 * chroma));
    end
  endfunction

  // Present one pixel and hold it until the block takes the request.
  task automatic send_pixel(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] r, input bit known, input hsv_t want);
    hsv_t    res;
    sector_t sec;
    predict_hsv(b, g, r, res, sec);
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    start    <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_hsv.insert(pending_hsv.size(), known ? want : res);
    sector_hits[sec]++;
    pixel_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_hsv.size() == 0) begin
        $display("%0t: unexpected result hue=%0d sat=%0d val=%0d", $time,
                 out_hue, out_saturation, out_brightness);
        err_count++;
      end else begin
        hsv_t exp_hsv;
        exp_hsv = pending_hsv.pop_front();
        if (out_hue !== exp_hsv.hue) begin
          $display("%0t: hue mismatch expected %0d actual %0d", $time, exp_hsv.hue, out_hue);
          err_count++;
        end
        if (out_saturation !== exp_hsv.saturation) begin
          $display("%0t: saturation mismatch expected %0d actual %0d", $time,
                   exp_hsv.saturation, out_saturation);
          err_count++;
        end
        if (out_brightness !== exp_hsv.brightness) begin
          $display("%0t: brightness mismatch expected %0d actual %0d", $time,
                   exp_hsv.brightness, out_brightness);
          err_count++;
        end
        checked_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_hsv.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    pixel_row_t pixel_table[] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0  }},  // black
      '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},  // white
      '{8'd128, 8'd128, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd128}},  // mid grey
      '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd170, 8'd255, 8'd255}},  // pure blue
      '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd85,  8'd255, 8'd255}},  // pure green
      '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},  // pure red
      '{8'd1,   8'd0,   8'd0,   1'b1, '{8'd170, 8'd255, 8'd1  }},  // dimmest blue
      '{8'd0,   8'd0,   8'd1,   1'b1, '{8'd0,   8'd255, 8'd1  }},  // dimmest red
      '{8'd255, 8'd255, 8'd0,   1'b0, '{default: '0}},             // blue ties green
      '{8'd255, 8'd0,   8'd255, 1'b0, '{default: '0}},             // blue ties red
      '{8'd0,   8'd255, 8'd255, 1'b0, '{default: '0}},             // green ties red
      '{8'd1,   8'd0,   8'd255, 1'b0, '{default: '0}},             // red max, hue wraps
      '{8'd0,   8'd1,   8'd255, 1'b0, '{default: '0}},             // red max, hue near zero
      '{8'd254, 8'd255, 8'd0,   1'b0, '{default: '0}},
      '{8'd255, 8'd254, 8'd254, 1'b0, '{default: '0}},             // smallest chroma
      '{8'hAA,  8'h55,  8'hAA,  1'b0, '{default: '0}},
      '{8'h55,  8'hAA,  8'h55,  1'b0, '{default: '0}},
      '{8'h0F,  8'hF0,  8'h3C,  1'b0, '{default: '0}},
      '{8'hF0,  8'h0F,  8'hC3,  1'b0, '{default: '0}}
    };
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] base;
    int              gap;
    bit              burst;

    pixel_count   = 0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_blue  <= '0;
    in_green <= '0;
    in_red   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    burst = 1'b0;
    for (int i = 0; i < pixel_table.size() + RANDOM_PIXELS; i++) begin
      if (i < pixel_table.size()) begin
        send_pixel(pixel_table[i].blue, pixel_table[i].green, pixel_table[i].red,
                   pixel_table[i].known, pixel_table[i].want);
      end else begin
        b = CH_W'($urandom);
        g = CH_W'($urandom);
        r = CH_W'($urandom);
        base = CH_W'($urandom);
        case ($urandom_range(0, 7))
          3: begin  // grey
            g = b;
            r = b;
          end
          4: begin  // two channels tie, third random
            case ($urandom_range(0, 2))
              0: g = b;
              1: r = b;
              default: r = g;
            endcase
          end
          5: begin  // small chroma around a random level
            b = base;
            g = (base > 8'd251) ? base - CH_W'($urandom_range(0, 3)) :
                                  base + CH_W'($urandom_range(0, 3));
            r = (base < 8'd4) ? base + CH_W'($urandom_range(0, 3)) :
                                base - CH_W'($urandom_range(0, 3));
          end
          6: begin  // channels pinned at the rails
            b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            g = $urandom_range(0, 1) ? 8'd255 : CH_W'($urandom);
            r = $urandom_range(0, 1) ? 8'd0 : CH_W'($urandom);
          end
          7: begin  // near black
            b = CH_W'($urandom_range(0, 3));
            g = CH_W'($urandom_range(0, 3));
            r = CH_W'($urandom_range(0, 3));
          end
          default: ;
        endcase
        send_pixel(b, g, r, 1'b0, '0);
      end
      // Switch between back-to-back stretches and randomly spaced requests.
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    // Drain, then watch a while longer for stray results.
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);

    $display("Sent %0d pixels (%0d table rows), checked %0d results, %0d mismatches.",
             pixel_count, pixel_table.size(), checked_count, err_count);
    $display("Hue sectors hit: grey %0d, blue %0d, green %0d, red rising %0d, red wrap %0d.",
             sector_hits[SEC_GREY], sector_hits[SEC_BLUE], sector_hits[SEC_GREEN],
             sector_hits[SEC_RED_UP], sector_hits[SEC_RED_WRAP]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
